>>> rtl/label_centroid_accumulator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the label centroid accumulator
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LABEL_CENTROID_ACCUMULATOR_CORE_MACROS_SVH
`define LABEL_CENTROID_ACCUMULATOR_CORE_MACROS_SVH

// Same-cycle implication
`define LCACC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LCACC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lcacc_pkg.sv
// ----------------------------------------------------------------------------
// lcacc_pkg
// Types and constants of the label centroid accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcacc_pkg;

  localparam int CmdW    = 2;
  localparam int CoordW  = 12;
  localparam int LabelW  = 16;
  localparam int CountW  = 24;
  localparam int SumW    = 36;
  localparam int LabelsW = 13;
  localparam int QuotW   = 12;
  localparam int StepW   = 4;
  localparam int EntryW  = CountW + 2 * SumW;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam int DefMaxLabels = 4096;
  localparam int DefMaxWidth  = 4096;
  localparam int DefMaxHeight = 4096;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [SumW-1:0]   sum_x;
    logic [SumW-1:0]   sum_y;
  } entry_t;

endpackage

>>> rtl/lcacc_ram.sv
// ----------------------------------------------------------------------------
// lcacc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcacc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/label_centroid_accumulator_core.sv
// ----------------------------------------------------------------------------
// label_centroid_accumulator_core
// Add pixel: a RAM read, then a write back of the updated entry; dropped
//   pixels, background pixels and no-ops return to idle without a store access.
// Query: read, 12-step restoring divide, output load; an empty label skips the
//   divide, and a label beyond the store goes straight to the output load.
// Reset and clear: sweep zeroing all MAX_LABELS RAM entries, one entry a cycle,
//   input held off meanwhile. Label count and overflow flag clear at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "label_centroid_accumulator_core_macros.svh"

module label_centroid_accumulator_core #(
  parameter int MAX_LABELS = lcacc_pkg::DefMaxLabels,
  parameter int MAX_WIDTH  = lcacc_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = lcacc_pkg::DefMaxHeight
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lcacc_pkg::CmdW-1:0]     command_i,
  input  logic [lcacc_pkg::CoordW-1:0]   pixel_x_i,
  input  logic [lcacc_pkg::CoordW-1:0]   pixel_y_i,
  input  logic [lcacc_pkg::LabelW-1:0]   region_label_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lcacc_pkg::QuotW-1:0]    mean_x_o,
  output logic [lcacc_pkg::QuotW-1:0]    mean_y_o,
  output logic [lcacc_pkg::CountW-1:0]   region_area_o,
  output logic [lcacc_pkg::LabelsW-1:0]  labels_in_use_o,
  output logic                           overflow_seen_o
);

  import lcacc_pkg::*;

  localparam int AddrW = $clog2(MAX_LABELS);
  localparam int LcntW = $clog2(MAX_LABELS + 1);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [AddrW-1:0]  sweep_addr_q, sweep_addr_d;
  logic [LcntW-1:0]  label_count_q, label_count_d;
  logic              overflow_q, overflow_d;
  logic              out_valid_q, out_valid_d;

  // per-transaction payload, no reset needed
  cmd_e              cmd_q;
  logic [CoordW-1:0] x_q;
  logic [CoordW-1:0] y_q;
  logic [AddrW-1:0]  addr_q;
  logic [CountW-1:0] count_q;
  logic [SumW-1:0]   rem_x_q;
  logic [SumW-1:0]   rem_y_q;
  logic [QuotW-1:0]  quot_x_q;
  logic [QuotW-1:0]  quot_y_q;
  logic [StepW-1:0]  step_q;

  logic [QuotW-1:0]   mean_x_q;
  logic [QuotW-1:0]   mean_y_q;
  logic [CountW-1:0]  area_q;
  logic [LabelsW-1:0] labels_q;
  logic               ovf_out_q;

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  cmd_e in_cmd;
  logic in_fire;
  logic lab_zero;
  logic lab_big;
  logic coord_big;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_cmd    = cmd_e'(command_i);
  assign in_fire   = in_valid_i && in_ready_o;
  assign lab_zero  = (region_label_i == '0);
  assign lab_big   = (32'(region_label_i) >= MAX_LABELS);
  assign coord_big = (32'(pixel_x_i) >= MAX_WIDTH) || (32'(pixel_y_i) >= MAX_HEIGHT);

  // --------------------------------------------------------------------------
  // Store: count and both sums share one RAM word
  // --------------------------------------------------------------------------
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic [EntryW-1:0] ram_rdata_raw;

  lcacc_ram #(
    .Width (EntryW),
    .Depth (MAX_LABELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (region_label_i[AddrW-1:0]),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // read-modify-write of the addressed entry
  logic   add_ok;
  entry_t upd_entry;

  assign add_ok = (ram_rdata.count != CountMax);

  always_comb begin
    upd_entry.count = ram_rdata.count + CountW'(1);
    upd_entry.sum_x = ram_rdata.sum_x + SumW'(x_q);
    upd_entry.sum_y = ram_rdata.sum_y + SumW'(y_q);
  end

  logic [31:0] lab_plus1;
  assign lab_plus1 = 32'(addr_q) + 32'd1;

  // --------------------------------------------------------------------------
  // Divider step: restoring, one quotient bit for x and y per cycle.
  // Means never exceed 4095 since each sum is at most count * 4095.
  // --------------------------------------------------------------------------
  logic [SumW-1:0] div_shifted;
  logic            ge_x;
  logic            ge_y;

  assign div_shifted = SumW'(count_q) << step_q;
  assign ge_x        = (rem_x_q >= div_shifted);
  assign ge_y        = (rem_y_q >= div_shifted);

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SWEEP: begin
        if (sweep_addr_q == AddrW'(MAX_LABELS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd)
            CMD_CLEAR: state_d = ST_SWEEP;
            CMD_ADD: begin
              if (!lab_zero && !lab_big && !coord_big) begin
                state_d = ST_READ;
              end
            end
            CMD_QUERY: state_d = lab_big ? ST_RESULT : ST_READ;
            CMD_NOP:   state_d = ST_IDLE;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        if (cmd_q == CMD_QUERY) begin
          state_d = (ram_rdata.count == '0) ? ST_RESULT : ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (step_q == '0) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_SWEEP;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control outputs and control-state updates
  // --------------------------------------------------------------------------
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = addr_q;
    ram_wdata     = upd_entry;
    sweep_addr_d  = sweep_addr_q;
    label_count_d = label_count_q;
    overflow_d    = overflow_q;
    out_valid_d   = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_SWEEP: begin
        ram_we       = 1'b1;
        ram_waddr    = sweep_addr_q;
        ram_wdata    = '0;
        sweep_addr_d = sweep_addr_q + AddrW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_CLEAR) begin
            sweep_addr_d  = '0;
            label_count_d = '0;
            overflow_d    = 1'b0;
          end else if (in_cmd == CMD_ADD && !lab_zero && lab_big) begin
            overflow_d = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (cmd_q == CMD_ADD && add_ok) begin
          ram_we = 1'b1;
          if (lab_plus1 > 32'(label_count_q)) begin
            label_count_d = LcntW'(lab_plus1);
          end
        end
      end
      ST_DIV: begin
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      sweep_addr_q  <= '0;
      label_count_q <= '0;
      overflow_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      sweep_addr_q  <= sweep_addr_d;
      label_count_q <= label_count_d;
      overflow_q    <= overflow_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_fire) begin
      cmd_q    <= in_cmd;
      x_q      <= pixel_x_i;
      y_q      <= pixel_y_i;
      addr_q   <= region_label_i[AddrW-1:0];
      // out-of-store query answers with zeros
      count_q  <= '0;
      rem_x_q  <= '0;
      rem_y_q  <= '0;
      quot_x_q <= '0;
      quot_y_q <= '0;
    end

    if (state_q == ST_READ && cmd_q == CMD_QUERY) begin
      count_q  <= ram_rdata.count;
      rem_x_q  <= ram_rdata.sum_x;
      rem_y_q  <= ram_rdata.sum_y;
      quot_x_q <= '0;
      quot_y_q <= '0;
      step_q   <= StepW'(QuotW - 1);
    end

    if (state_q == ST_DIV) begin
      if (ge_x) begin
        rem_x_q <= rem_x_q - div_shifted;
      end
      if (ge_y) begin
        rem_y_q <= rem_y_q - div_shifted;
      end
      quot_x_q <= {quot_x_q[QuotW-2:0], ge_x};
      quot_y_q <= {quot_y_q[QuotW-2:0], ge_y};
      step_q   <= step_q - StepW'(1);
    end

    // output register: lets the next transaction in while a result waits
    if (state_q == ST_RESULT && out_free) begin
      mean_x_q  <= quot_x_q;
      mean_y_q  <= quot_y_q;
      area_q    <= count_q;
      labels_q  <= LabelsW'(32'(label_count_q));
      ovf_out_q <= overflow_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mean_x_o        = mean_x_q;
  assign mean_y_o        = mean_y_q;
  assign region_area_o   = area_q;
  assign labels_in_use_o = labels_q;
  assign overflow_seen_o = ovf_out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `LCACC_ASSERT_SAME(a_div_exact, clk_i, rst_ni,
    (state_q == ST_RESULT) && (count_q != '0),
    (rem_x_q < SumW'(count_q)) && (rem_y_q < SumW'(count_q)),
    "divider remainder not below divisor")
  `LCACC_ASSERT_SAME(a_lcnt_range, clk_i, rst_ni, 1'b1,
    32'(label_count_q) <= MAX_LABELS, "label count beyond store depth")
  `LCACC_ASSERT_NEXT(a_clear_takes, clk_i, rst_ni, in_fire && (in_cmd == CMD_CLEAR),
    (state_q == ST_SWEEP) && (label_count_q == '0) && !overflow_q,
    "clear transaction did not reset state")
  `LCACC_ASSERT_SAME(a_no_write_clash, clk_i, rst_ni, ram_we,
    (state_q == ST_SWEEP) || ((state_q == ST_READ) && (cmd_q == CMD_ADD)),
    "store written outside sweep or pixel update")

endmodule
